// ===== design/stb_pkg.sv =====
// stb_pkg: shared types and constants for the software timer bank
// no dependencies; imported by stb_ctrl, stb_datapath and software_timer_bank
package stb_pkg;

   // table size and derived widths
   localparam int NUM_TIMERS = 16;
   localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
   localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   // field widths
   localparam int TIME_W  = 32;
   localparam int INTV_W  = 31;
   localparam int IDENT_W = 32;
   localparam int TAG_W   = 16;

   // smallest reload step of a repeating timer, 0.0001 s rounded up in Q16.16
   localparam logic [INTV_W-1:0] MIN_RELOAD = INTV_W'(7);

   // saturation limits of a signed Q16.16 time
   localparam logic [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
   localparam logic [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};

   // request opcodes
   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_CANCEL = 2'd1,
      OP_TICK   = 2'd2
   } op_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_CANCEL = 2'd1,
      KIND_EXPIRY = 2'd2,
      KIND_DONE   = 2'd3
   } kind_type;

   // datapath operations issued by the controller
   typedef enum logic [2:0] {
      DP_NOP,
      DP_LOAD,
      DP_ADD,
      DP_CANCEL_STEP,
      DP_CANCEL_MISS,
      DP_TICK_SUB,
      DP_TICK_UPD,
      DP_TICK_DONE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_end;     // scan index has reached the occupied count
      logic slot_cancel;  // current slot is marked cancelled
      logic cancel_hit;   // current slot is live and matches the cancel id
   } dp_status_type;

endpackage

// ===== design/stb_ctrl.sv =====
// stb_ctrl: controller state machine of the software timer bank
// depends on stb_pkg; drives stb_datapath through dp_cmd_type / dp_status_type
module stb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [1:0]            req_opcode,
   input  stb_pkg::dp_status_type status,
   output stb_pkg::dp_cmd_type   cmd,
   output logic                  busy
);
   import stb_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_CANCEL,
      ST_TICK_SUB,
      ST_TICK_UPD
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff,  busy_in;

   // next state and datapath command
   always_comb begin
      state_in = state_ff;
      cmd.op   = DP_NOP;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.op = DP_LOAD;
               case (op_type'(req_opcode))
                  OP_ADD:    state_in = ST_ADD;
                  OP_CANCEL: state_in = ST_CANCEL;
                  OP_TICK:   state_in = ST_TICK_SUB;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD: begin
            cmd.op   = DP_ADD;
            state_in = ST_IDLE;
         end
         ST_CANCEL: begin
            if (status.scan_end) begin
               cmd.op   = DP_CANCEL_MISS;
               state_in = ST_IDLE;
            end else begin
               cmd.op = DP_CANCEL_STEP;
               if (status.cancel_hit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_TICK_SUB: begin
            if (status.scan_end) begin
               cmd.op   = DP_TICK_DONE;
               state_in = ST_IDLE;
            end else begin
               cmd.op = DP_TICK_SUB;
               // cancelled slots are dropped in place, live ones go on to update
               if (!status.slot_cancel) begin
                  state_in = ST_TICK_UPD;
               end
            end
         end
         ST_TICK_UPD: begin
            cmd.op   = DP_TICK_UPD;
            state_in = ST_TICK_SUB;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   // state and registered busy
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

   // busy mirrors a non-idle state
   ap_busy_state: assert property (@(posedge clock) disable iff (reset)
      busy_ff == (state_ff != ST_IDLE))
      else $error("busy out of step with state");

   // an update always follows a subtract of a live slot
   ap_upd_after_sub: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TICK_UPD |-> $past(state_ff) == ST_TICK_SUB)
      else $error("tick update without subtract");

   // no item taken while the sequence runs
   ap_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cmd.op != DP_LOAD)
      else $error("load issued while busy");

endmodule

// ===== design/stb_datapath.sv =====
// stb_datapath: timer slot table, scan counters, time arithmetic and result register
// depends on stb_pkg; controlled by stb_ctrl
module stb_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  stb_pkg::dp_cmd_type       cmd,
   output stb_pkg::dp_status_type    status,
   input  logic [31:0]               req_duration,
   input  logic                      req_repeat_flag,
   input  logic [15:0]               req_callback_tag,
   input  logic [31:0]               req_target_id,
   input  logic [31:0]               req_elapsed,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_kind,
   output logic [31:0]               rsp_timer_ident,
   output logic [15:0]               rsp_expired_tag,
   output logic                      rsp_success,
   output logic                      rsp_last
);
   import stb_pkg::*;

   // slot table, flip-flops read at the scan index only
   logic [TIME_W-1:0]  rem_ff   [NUM_TIMERS];
   logic [INTV_W-1:0]  intv_ff  [NUM_TIMERS];
   logic               rpt_ff   [NUM_TIMERS];
   logic               canc_ff  [NUM_TIMERS];
   logic [IDENT_W-1:0] ident_ff [NUM_TIMERS];
   logic [TAG_W-1:0]   tag_ff   [NUM_TIMERS];

   // control counters
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   rd_ff,    rd_in;
   logic [CNT_W-1:0]   wr_ff,    wr_in;
   logic [IDENT_W-1:0] next_id_ff, next_id_in;

   // captured item payload and tick work register
   logic [TIME_W-1:0]  dur_ff;
   logic               rep_ff;
   logic [TAG_W-1:0]   tagin_ff;
   logic [IDENT_W-1:0] target_ff;
   logic [INTV_W-1:0]  dt_ff;
   logic [TIME_W-1:0]  sub_ff, sub_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           kind_ff,  kind_in;
   logic [IDENT_W-1:0] ident_o_ff, ident_o_in;
   logic [TAG_W-1:0]   tag_o_ff, tag_o_in;
   logic               ok_ff,    ok_in;
   logic               last_ff,  last_in;

   // slot write port
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [TIME_W-1:0]  wr_rem;
   logic [INTV_W-1:0]  wr_intv;
   logic               wr_rpt;
   logic [IDENT_W-1:0] wr_ident;
   logic [TAG_W-1:0]   wr_tag;
   logic               canc_set;

   logic [IDX_W-1:0]   rd_idx;
   logic [TIME_W:0]    diff;
   logic [TIME_W:0]    sum;
   logic [INTV_W-1:0]  step;
   logic               expired;
   logic [IDENT_W-1:0] id_inc;

   assign rd_idx = rd_ff[IDX_W-1:0];

   // status back to the controller
   assign status.scan_end    = (rd_ff == count_ff);
   assign status.slot_cancel = canc_ff[rd_idx];
   assign status.cancel_hit  = (ident_ff[rd_idx] == target_ff) && !canc_ff[rd_idx];

   // saturating subtract of the elapsed time, clamps at the most negative value
   always_comb begin
      diff = {rem_ff[rd_idx][TIME_W-1], rem_ff[rd_idx]} - {2'b00, dt_ff};
      if (diff[TIME_W] != diff[TIME_W-1]) begin
         sub_in = TIME_MIN;
      end else begin
         sub_in = diff[TIME_W-1:0];
      end
   end

   // reload step and expiry test on the registered difference
   assign step    = (intv_ff[rd_idx] < MIN_RELOAD) ? MIN_RELOAD : intv_ff[rd_idx];
   assign sum     = {sub_ff[TIME_W-1], sub_ff} + {2'b00, step};
   assign expired = sub_ff[TIME_W-1] || (sub_ff == '0);
   assign id_inc  = next_id_ff + IDENT_W'(1);

   // counters, result and write port
   always_comb begin
      count_in     = count_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      next_id_in   = next_id_ff;
      rsp_valid_in = 1'b0;
      kind_in      = kind_ff;
      ident_o_in   = ident_o_ff;
      tag_o_in     = tag_o_ff;
      ok_in        = ok_ff;
      last_in      = last_ff;
      wr_en        = 1'b0;
      wr_addr      = rd_idx;
      wr_rem       = sub_ff;
      wr_intv      = intv_ff[rd_idx];
      wr_rpt       = rpt_ff[rd_idx];
      wr_ident     = ident_ff[rd_idx];
      wr_tag       = tag_ff[rd_idx];
      canc_set     = 1'b0;
      case (cmd.op)
         DP_LOAD: begin
            rd_in = '0;
            wr_in = '0;
         end
         DP_ADD: begin
            rsp_valid_in = 1'b1;
            kind_in      = KIND_ADD;
            tag_o_in     = '0;
            last_in      = 1'b1;
            if (dur_ff[TIME_W-1] || count_ff == CNT_W'(NUM_TIMERS)) begin
               ident_o_in = '0;
               ok_in      = 1'b0;
            end else begin
               ident_o_in = next_id_ff;
               ok_in      = 1'b1;
               next_id_in = (id_inc == '0) ? IDENT_W'(1) : id_inc;
               count_in   = count_ff + CNT_W'(1);
               wr_en      = 1'b1;
               wr_addr    = count_ff[IDX_W-1:0];
               wr_rem     = dur_ff;
               wr_intv    = dur_ff[INTV_W-1:0];
               wr_rpt     = rep_ff;
               wr_ident   = next_id_ff;
               wr_tag     = tagin_ff;
            end
         end
         DP_CANCEL_STEP: begin
            if (status.cancel_hit) begin
               canc_set     = 1'b1;
               rsp_valid_in = 1'b1;
               kind_in      = KIND_CANCEL;
               ident_o_in   = '0;
               tag_o_in     = '0;
               ok_in        = 1'b1;
               last_in      = 1'b1;
            end else begin
               rd_in = rd_ff + CNT_W'(1);
            end
         end
         DP_CANCEL_MISS: begin
            rsp_valid_in = 1'b1;
            kind_in      = KIND_CANCEL;
            ident_o_in   = '0;
            tag_o_in     = '0;
            ok_in        = 1'b0;
            last_in      = 1'b1;
         end
         DP_TICK_SUB: begin
            // a cancelled slot is skipped and so squeezed out
            if (canc_ff[rd_idx]) begin
               rd_in = rd_ff + CNT_W'(1);
            end
         end
         DP_TICK_UPD: begin
            if (expired) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_EXPIRY;
               ident_o_in   = ident_ff[rd_idx];
               tag_o_in     = tag_ff[rd_idx];
               ok_in        = 1'b0;
               last_in      = 1'b0;
            end
            if (expired && rpt_ff[rd_idx]) begin
               wr_rem = (sum[TIME_W] != sum[TIME_W-1]) ? TIME_MAX : sum[TIME_W-1:0];
            end
            // keep live slots, packed down to the write index
            if (!expired || rpt_ff[rd_idx]) begin
               wr_en   = 1'b1;
               wr_addr = wr_ff[IDX_W-1:0];
               wr_in   = wr_ff + CNT_W'(1);
            end
            rd_in = rd_ff + CNT_W'(1);
         end
         DP_TICK_DONE: begin
            count_in     = wr_ff;
            rsp_valid_in = 1'b1;
            kind_in      = KIND_DONE;
            ident_o_in   = '0;
            tag_o_in     = '0;
            ok_in        = 1'b0;
            last_in      = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_ff        <= '0;
         wr_ff        <= '0;
         next_id_ff   <= IDENT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_ff        <= rd_in;
         wr_ff        <= wr_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.op == DP_LOAD) begin
         dur_ff    <= req_duration;
         rep_ff    <= req_repeat_flag;
         tagin_ff  <= req_callback_tag;
         target_ff <= req_target_id;
         dt_ff     <= req_elapsed[TIME_W-1] ? '0 : req_elapsed[INTV_W-1:0];
      end
      if (cmd.op == DP_TICK_SUB) begin
         sub_ff <= sub_in;
      end
      kind_ff    <= kind_in;
      ident_o_ff <= ident_o_in;
      tag_o_ff   <= tag_o_in;
      ok_ff      <= ok_in;
      last_ff    <= last_in;
   end

   // slot table, one write address plus the cancel mark
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_TIMERS; k++) begin
         if (wr_en && wr_addr == IDX_W'(k)) begin
            rem_ff[k]   <= wr_rem;
            intv_ff[k]  <= wr_intv;
            rpt_ff[k]   <= wr_rpt;
            canc_ff[k]  <= 1'b0;
            ident_ff[k] <= wr_ident;
            tag_ff[k]   <= wr_tag;
         end else if (canc_set && rd_idx == IDX_W'(k)) begin
            canc_ff[k]  <= 1'b1;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_timer_ident = ident_o_ff;
   assign rsp_expired_tag = tag_o_ff;
   assign rsp_success     = ok_ff;
   assign rsp_last        = last_ff;

   // occupancy never exceeds the table
   ap_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(NUM_TIMERS))
      else $error("occupied count beyond table size");

   // packing never overtakes the scan
   ap_pack_order: assert property (@(posedge clock) disable iff (reset)
      wr_ff <= rd_ff)
      else $error("write index ahead of read index");

   // the closing result of a tick leaves the packed count
   ap_done_count: assert property (@(posedge clock) disable iff (reset)
      cmd.op == DP_TICK_DONE |=> count_ff == $past(wr_ff))
      else $error("count not updated by tick");

   // an expiry is never the final result
   ap_expiry_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == KIND_EXPIRY |-> !last_ff)
      else $error("expiry marked last");

endmodule

// ===== design/software_timer_bank.sv =====
// software_timer_bank: top level, joins the controller and the datapath
// depends on stb_pkg, stb_ctrl and stb_datapath
//
// Usage: an item is taken when start is high and busy is low. req_opcode
// selects add (req_duration, req_repeat_flag, req_callback_tag), cancel
// (req_target_id) or tick (req_elapsed); the unused opcode is taken and
// ignored. Results appear on the rsp_ ports for one cycle each, marked by
// rsp_valid; the receiver cannot stall, every strobe is a delivered result.
// rsp_last marks the final result of an item, and busy falls with it.
// Add answers from the ADD state after acceptance. Cancel walks the slots
// one per cycle until the matching slot or the occupied count is reached.
// Tick visits each live slot with a saturating subtract, then an expiry
// test with reload and packing, and skips each cancelled slot. Expiries
// come in slot order, then the tick-done result. Items are handled one at
// a time, the slot scan of the controller setting the rate.
// Reset (synchronous, active high) empties the table and restarts ids at 1;
// no clearing pass is needed, the slot store is only read below the count.
module software_timer_bank (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_duration,
   input  logic        req_repeat_flag,
   input  logic [15:0] req_callback_tag,
   input  logic [31:0] req_target_id,
   input  logic [31:0] req_elapsed,
   output logic        rsp_valid,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_timer_ident,
   output logic [15:0] rsp_expired_tag,
   output logic        rsp_success,
   output logic        rsp_last
);
   import stb_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencing
   stb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy)
   );

   // slot table and arithmetic
   stb_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_duration     (req_duration),
      .req_repeat_flag  (req_repeat_flag),
      .req_callback_tag (req_callback_tag),
      .req_target_id    (req_target_id),
      .req_elapsed      (req_elapsed),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_timer_ident  (rsp_timer_ident),
      .rsp_expired_tag  (rsp_expired_tag),
      .rsp_success      (rsp_success),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for software_timer_bank, directed table then random items
// depends on stb_pkg and software_timer_bank; results checked against an in-bench timer predictor
module testbench;
   import stb_pkg::*;

   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int  DIRECTED_ROWS  = 22;
   localparam int  RANDOM_ITEMS   = 148;
   localparam int  SETTLE_CYCLES  = 60;
   localparam int  WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [1:0]         kind;
      logic [IDENT_W-1:0] ident;
      logic [TAG_W-1:0]   tag;
      logic               success;
      logic               last;
   } timer_result_type;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [TIME_W-1:0] duration;
      logic              periodic;
      logic [TAG_W-1:0]  tag;
      logic [31:0]       target;
      logic [TIME_W-1:0] elapsed;
      logic              typed;
      timer_result_type  answer;
   } stim_row_type;

   // answers that can be read straight off the behaviour
   localparam timer_result_type NO_ANSWER     = '0;
   localparam timer_result_type ADD_REJECTED  = '{KIND_ADD, 32'd0, 16'd0, 1'b0, 1'b1};
   localparam timer_result_type CANCEL_MISSED = '{KIND_CANCEL, 32'd0, 16'd0, 1'b0, 1'b1};
   localparam timer_result_type CANCEL_HIT    = '{KIND_CANCEL, 32'd0, 16'd0, 1'b1, 1'b1};
   localparam timer_result_type TICK_EMPTY    = '{KIND_DONE, 32'd0, 16'd0, 1'b0, 1'b1};

   // directed table: extremes, rejections, cancel hits and misses, negative saturation
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{OP_TICK,   32'h0, 1'b0, 16'h0, 32'h0, 32'h0, 1'b1, TICK_EMPTY},
      '{OP_CANCEL, 32'h0, 1'b0, 16'h0, 32'h0, 32'h0, 1'b1, CANCEL_MISSED},
      '{OP_ADD, 32'h0, 1'b0, 16'h0000, 32'h0, 32'h0, 1'b1,
        '{KIND_ADD, 32'd1, 16'd0, 1'b1, 1'b1}},
      '{OP_ADD, 32'h7FFF_FFFF, 1'b1, 16'hFFFF, 32'h0, 32'h0, 1'b1,
        '{KIND_ADD, 32'd2, 16'd0, 1'b1, 1'b1}},
      '{OP_ADD, 32'hFFFF_FFFF, 1'b0, 16'h0, 32'h0, 32'h0, 1'b1, ADD_REJECTED},
      '{OP_ADD, 32'h8000_0000, 1'b1, 16'hFFFF, 32'h0, 32'h0, 1'b1, ADD_REJECTED},
      '{OP_ADD, 32'h1, 1'b1, 16'h1234, 32'h0, 32'h0, 1'b1,
        '{KIND_ADD, 32'd3, 16'd0, 1'b1, 1'b1}},
      '{OP_ADD, 32'h0001_0000, 1'b0, 16'hA5A5, 32'h0, 32'h0, 1'b1,
        '{KIND_ADD, 32'd4, 16'd0, 1'b1, 1'b1}},
      '{OP_CANCEL, 32'h0, 1'b0, 16'h0, 32'd4, 32'h0, 1'b1, CANCEL_HIT},
      '{OP_CANCEL, 32'h0, 1'b0, 16'h0, 32'd4, 32'h0, 1'b1, CANCEL_MISSED},
      '{OP_ADD, 32'h5, 1'b1, 16'h00FF, 32'h0, 32'h0, 1'b1,
        '{KIND_ADD, 32'd5, 16'd0, 1'b1, 1'b1}},
      '{OP_ADD, 32'h0003_0000, 1'b0, 16'h5A5A, 32'h0, 32'h0, 1'b1,
        '{KIND_ADD, 32'd6, 16'd0, 1'b1, 1'b1}},
      '{OP_TICK, 32'h0, 1'b0, 16'h0, 32'h0, 32'h8000_0000, 1'b0, NO_ANSWER},
      '{OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0,
        NO_ANSWER},
      '{OP_TICK, 32'h0, 1'b0, 16'h0, 32'h0, 32'h1, 1'b0, NO_ANSWER},
      '{OP_TICK, 32'h0, 1'b0, 16'h0, 32'h0, 32'h0001_0000, 1'b0, NO_ANSWER},
      '{OP_TICK, 32'h0, 1'b0, 16'h0, 32'h0, 32'h7FFF_FFFF, 1'b0, NO_ANSWER},
      '{OP_TICK, 32'h0, 1'b0, 16'h0, 32'h0, 32'h7FFF_FFFF, 1'b0, NO_ANSWER},
      '{OP_ADD, 32'h0, 1'b1, 16'h8000, 32'h0, 32'h0, 1'b0, NO_ANSWER},
      '{OP_CANCEL, 32'h0, 1'b0, 16'h0, 32'd2, 32'h0, 1'b0, NO_ANSWER},
      '{OP_CANCEL, 32'h0, 1'b0, 16'h0, 32'hFFFF_FFFF, 32'h0, 1'b1, CANCEL_MISSED},
      '{OP_TICK, 32'h0, 1'b0, 16'h0, 32'h0, 32'h0, 1'b0, NO_ANSWER}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_opcode = OP_ADD;
   logic [31:0] req_duration = '0;
   logic        req_repeat_flag = 1'b0;
   logic [15:0] req_callback_tag = '0;
   logic [31:0] req_target_id = '0;
   logic [31:0] req_elapsed = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_timer_ident;
   logic [15:0] rsp_expired_tag;
   logic        rsp_success;
   logic        rsp_last;

   // shadow copy of the timer table
   logic signed [TIME_W-1:0] shadow_remaining [NUM_TIMERS];
   logic [INTV_W-1:0]        shadow_interval  [NUM_TIMERS];
   logic                     shadow_periodic  [NUM_TIMERS];
   logic                     shadow_cancelled [NUM_TIMERS];
   logic [IDENT_W-1:0]       shadow_ident     [NUM_TIMERS];
   logic [TAG_W-1:0]         shadow_tag       [NUM_TIMERS];
   int                       shadow_count = 0;
   logic [IDENT_W-1:0]       shadow_next_ident = 32'd1;

   timer_result_type pending_results [$];
   int               mismatch_count = 0;
   int               quiet_cycles = 0;

   software_timer_bank i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_duration    (req_duration),
      .req_repeat_flag (req_repeat_flag),
      .req_callback_tag(req_callback_tag),
      .req_target_id   (req_target_id),
      .req_elapsed     (req_elapsed),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_timer_ident (rsp_timer_ident),
      .rsp_expired_tag (rsp_expired_tag),
      .rsp_success     (rsp_success),
      .rsp_last        (rsp_last)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // clamp a wide time to the signed Q16.16 range
   function automatic logic signed [TIME_W-1:0] saturate_time(input longint value);
      if (value > longint'(32'sh7FFF_FFFF))
         return TIME_MAX;
      if (value < -longint'(64'h8000_0000))
         return TIME_MIN;
      return value[TIME_W-1:0];
   endfunction

   // appends one expected result behind those still outstanding
   function automatic void queue_result(input timer_result_type result);
      pending_results.insert(pending_results.size(), result);
   endfunction

   // works out the results of one item and moves the shadow table on
   function automatic void predict_timer_results(input logic [1:0] opcode,
         input logic [31:0] duration, input logic periodic, input logic [15:0] tag,
         input logic [31:0] target, input logic [31:0] elapsed);
      longint     decrement;
      longint     reload_step;
      int         keep;
      logic       found;
      logic [31:0] new_ident;
      found = 1'b0;
      keep  = 0;
      case (opcode)
         OP_ADD: begin
            if ($signed(duration) < 0 || shadow_count >= NUM_TIMERS) begin
               queue_result(ADD_REJECTED);
            end else begin
               new_ident = shadow_next_ident;
               shadow_next_ident = shadow_next_ident + 1;
               if (shadow_next_ident == 0)
                  shadow_next_ident = 32'd1;
               shadow_remaining[shadow_count] = duration;
               shadow_interval[shadow_count]  = duration[INTV_W-1:0];
               shadow_periodic[shadow_count]  = periodic;
               shadow_cancelled[shadow_count] = 1'b0;
               shadow_ident[shadow_count]     = new_ident;
               shadow_tag[shadow_count]       = tag;
               shadow_count = shadow_count + 1;
               queue_result('{KIND_ADD, new_ident, 16'd0, 1'b1, 1'b1});
            end
         end
         OP_CANCEL: begin
            // first live entry with the id wins
            for (int i = 0; i < shadow_count; i++) begin
               if (!found && shadow_ident[i] == target && !shadow_cancelled[i]) begin
                  shadow_cancelled[i] = 1'b1;
                  found = 1'b1;
               end
            end
            queue_result(found ? CANCEL_HIT : CANCEL_MISSED);
         end
         OP_TICK: begin
            // negative elapsed time counts as none
            decrement = ($signed(elapsed) < 0) ? 0 : longint'($signed(elapsed));
            for (int i = 0; i < shadow_count; i++) begin
               if (shadow_cancelled[i])
                  continue;
               shadow_remaining[i] = saturate_time(longint'(shadow_remaining[i]) - decrement);
               if (shadow_remaining[i] > 0)
                  continue;
               queue_result('{KIND_EXPIRY, shadow_ident[i], shadow_tag[i], 1'b0, 1'b0});
               if (shadow_periodic[i]) begin
                  reload_step = longint'(shadow_interval[i]);
                  if (reload_step < longint'(MIN_RELOAD))
                     reload_step = longint'(MIN_RELOAD);
                  shadow_remaining[i] = saturate_time(longint'(shadow_remaining[i]) +
                                                      reload_step);
               end else begin
                  shadow_cancelled[i] = 1'b1;
               end
            end
            // squeeze out cancelled entries, order kept
            for (int i = 0; i < shadow_count; i++) begin
               if (shadow_cancelled[i])
                  continue;
               shadow_remaining[keep] = shadow_remaining[i];
               shadow_interval[keep]  = shadow_interval[i];
               shadow_periodic[keep]  = shadow_periodic[i];
               shadow_cancelled[keep] = 1'b0;
               shadow_ident[keep]     = shadow_ident[i];
               shadow_tag[keep]       = shadow_tag[i];
               keep = keep + 1;
            end
            shadow_count = keep;
            queue_result(TICK_EMPTY);
         end
         default: begin
            // unused opcode: taken, no result
         end
      endcase
   endfunction

   // holds one item on the request ports until the block takes it
   task automatic issue_item(input logic [1:0] opcode, input logic [31:0] duration,
         input logic periodic, input logic [15:0] tag, input logic [31:0] target,
         input logic [31:0] elapsed, input bit gaps);
      if (gaps) begin
         while ($urandom_range(99) < 24) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start            <= 1'b1;
      req_opcode       <= opcode;
      req_duration     <= duration;
      req_repeat_flag  <= periodic;
      req_callback_tag <= tag;
      req_target_id    <= target;
      req_elapsed      <= elapsed;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      predict_timer_results(opcode, duration, periodic, tag, target, elapsed);
   endtask

   function automatic void compare_field(input string name, input logic [31:0] want,
         input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      timer_result_type oldest;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("result with nothing outstanding: kind %0d ident %0h", rsp_kind,
                   rsp_timer_ident);
            mismatch_count++;
         end else begin
            oldest = pending_results.pop_front();
            compare_field("kind", 32'(oldest.kind), 32'(rsp_kind));
            compare_field("timer_ident", oldest.ident, rsp_timer_ident);
            compare_field("expired_tag", 32'(oldest.tag), 32'(rsp_expired_tag));
            compare_field("success", 32'(oldest.success), 32'(rsp_success));
            compare_field("last", 32'(oldest.last), 32'(rsp_last));
         end
      end
   end

   // watchdog on cycles with neither an item taken nor a result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      int          counted;
      int          pick;
      int          add_weight;
      logic [1:0]  opcode;
      logic [31:0] duration;
      logic [31:0] target;
      logic [31:0] elapsed;
      counted = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table; typed answers replace the computed ones
      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         issue_item(directed_rows[row].opcode, directed_rows[row].duration,
                    directed_rows[row].periodic, directed_rows[row].tag,
                    directed_rows[row].target, directed_rows[row].elapsed, 1'b1);
         if (directed_rows[row].typed) begin
            void'(pending_results.pop_back());
            queue_result(directed_rows[row].answer);
         end
      end

      // random items, add-heavy stretches to fill the table now and then
      while (counted < RANDOM_ITEMS) begin
         duration = $urandom;
         target   = $urandom;
         elapsed  = $urandom;
         add_weight = (counted % 60 < 25) ? 60 : 38;
         pick = $urandom_range(99);
         if (pick < 4) begin
            opcode = OP_UNUSED;
         end else if (pick < 4 + add_weight) begin
            opcode = OP_ADD;
            pick = $urandom_range(99);
            if (pick < 65)
               duration = $urandom_range(32'h0004_0000);
            else if (pick < 78)
               duration = $urandom_range(8);
            else if (pick < 90)
               duration = $urandom & 32'h7FFF_FFFF;
         end else if (pick < 4 + add_weight + 20) begin
            opcode = OP_CANCEL;
            if (shadow_count > 0 && $urandom_range(99) < 80)
               target = shadow_ident[$urandom_range(shadow_count - 1)];
         end else begin
            opcode = OP_TICK;
            pick = $urandom_range(99);
            if (pick < 70)
               elapsed = $urandom_range(32'h0002_0000);
            else if (pick < 85)
               elapsed = $urandom_range(16);
         end
         if (opcode != OP_UNUSED)
            counted++;
         issue_item(opcode, duration, 1'($urandom_range(1)), 16'($urandom_range(65535)),
                    target, elapsed, !(counted >= 60 && counted < 110));
      end
      start <= 1'b0;

      // drain, then let the block settle
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
